### hw/rtl/css_pkg.sv
// shared types and codes for the clock sync servo
package css_pkg;

  localparam logic [1:0] OP_SYNC     = 2'd0;
  localparam logic [1:0] OP_FOLLOWUP = 2'd1;
  localparam logic [1:0] OP_SEND     = 2'd2;
  localparam logic [1:0] OP_RESPONSE = 2'd3;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_STEP     = 3'd1;
  localparam logic [2:0] ACT_SLEW     = 3'd2;
  localparam logic [2:0] ACT_PATH_OK  = 3'd3;
  localparam logic [2:0] ACT_PATH_BAD = 3'd4;
  localparam logic [2:0] ACT_SEND     = 3'd5;
  localparam logic [2:0] ACT_PENDING  = 3'd6;

  localparam logic [2:0] REG_STEP_THR  = 3'd0;
  localparam logic [2:0] REG_ADJ_PER   = 3'd1;
  localparam logic [2:0] REG_SLEW_LIM  = 3'd2;
  localparam logic [2:0] REG_SLEW_EN   = 3'd3;
  localparam logic [2:0] REG_MAX_PATH  = 3'd4;
  localparam logic [2:0] REG_PATH_CNT  = 3'd5;
  localparam logic [2:0] REG_DRIFT_WIN = 3'd6;
  localparam logic [2:0] REG_SYNC_TMO  = 3'd7;

  localparam logic [19:0] NS_PER_MS = 20'd1000000;
  localparam logic [9:0]  MS_PER_S  = 10'd1000;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

endpackage

### hw/rtl/clock_sync_servo_top.sv
// clock sync servo: offset step/slew, drift averaging and path delay filter
// a slew runs up to five divisions in one shared divider plus a shift-add multiply
// one request at a time: input stalls until the result sits in the output register
// reset (async, active low) clears all servo state and loads register defaults
module clock_sync_servo_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [62:0]        local_time_ns_i,
  input  logic signed [63:0] remote_time_ns_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         action_o,
  output logic signed [63:0] value_ns_o,
  output logic signed [27:0] drift_estimate_ppb_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i
);
  import css_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_INT  = 4'd2;
  localparam logic [3:0] ST_SMP  = 4'd3;
  localparam logic [3:0] ST_ADJ  = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_MFX  = 4'd6;
  localparam logic [3:0] ST_DRF  = 4'd7;
  localparam logic [3:0] ST_PRD  = 4'd8;
  localparam logic [3:0] ST_END  = 4'd9;
  localparam logic [3:0] ST_PTH  = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;

  function automatic logic signed [63:0] times1000(input logic signed [63:0] x);
    times1000 = (x <<< 10) - (x <<< 4) - (x <<< 3);
  endfunction

  // configuration
  logic [15:0] step_thr_q, adj_per_q;
  logic [16:0] slew_lim_q;
  logic        slew_en_q;
  logic [9:0]  max_path_q;
  logic [7:0]  path_cap_q;
  logic [30:0] drift_win_q, sync_tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_thr_q  <= 16'd100;
      adj_per_q   <= 16'd970;
      slew_lim_q  <= 17'd20000;
      slew_en_q   <= 1'b1;
      max_path_q  <= 10'd10;
      path_cap_q  <= 8'd100;
      drift_win_q <= 31'd600000;
      sync_tmo_q  <= 31'd300000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STEP_THR:  step_thr_q  <= cfg_data_i[15:0];
        REG_ADJ_PER:   adj_per_q   <= cfg_data_i[15:0];
        REG_SLEW_LIM:  slew_lim_q  <= cfg_data_i[16:0];
        REG_SLEW_EN:   slew_en_q   <= cfg_data_i[0];
        REG_MAX_PATH:  max_path_q  <= cfg_data_i[9:0];
        REG_PATH_CNT:  path_cap_q  <= cfg_data_i[7:0];
        REG_DRIFT_WIN: drift_win_q <= cfg_data_i;
        REG_SYNC_TMO:  sync_tmo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // servo state
  logic [3:0]         state_q;
  logic signed [63:0] sync_local_q, sync_remote_q, req_time_q, path_avg_q;
  logic [7:0]         path_cnt_q;
  logic signed [63:0] last_off_q, last_off_time_q, last_adj_q;
  logic signed [31:0] drift_total_q;
  logic signed [27:0] drift_q;
  // working registers
  logic signed [63:0] delta_q, now_q, sample_q, mul_a_q, acc_q;
  logic signed [31:0] interval_q;
  logic [31:0]        mul_b_q;
  logic [4:0]         mul_cnt_q;
  logic [2:0]         res_act_q;
  logic signed [63:0] res_val_q;
  logic               out_valid_q;
  logic [2:0]         out_act_q;
  logic signed [63:0] out_val_q;
  logic signed [27:0] out_drift_q;
  div_req_t           div_req_q;
  logic               div_done;
  logic signed [63:0] div_q;

  css_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // combinational helpers
  logic signed [63:0] ps_sum, ps_half, fu_delta, delta_mag, step_time;
  logic [35:0]        thr_ns;
  logic [29:0]        path_lim_ns;
  logic [7:0]         cnt_next;
  logic [26:0]        slew_lim_ppb;
  logic signed [63:0] s_sum, s_new, drf_next, prod_fix, off_max, adj_sum;
  logic signed [32:0] tot_sum;
  logic signed [31:0] tot_new, int_clamp;
  logic [16:0]        period;
  logic signed [44:0] drift_prod;

  assign ps_sum      = (remote_time_ns_i - req_time_q) + (path_avg_q - last_off_q);
  assign ps_half     = $signed(ps_sum + {63'd0, ps_sum[63]}) >>> 1;
  assign path_lim_ns = max_path_q * NS_PER_MS;
  assign cnt_next    = (path_cnt_q < path_cap_q) ? path_cnt_q + 8'd1 : path_cnt_q;
  assign fu_delta    = (remote_time_ns_i - sync_local_q) + path_avg_q;
  assign delta_mag   = delta_q[63] ? 64'sd0 - delta_q : delta_q;
  assign thr_ns      = step_thr_q * NS_PER_MS;
  assign step_time   = (now_q - sync_local_q) + sync_remote_q;
  assign int_clamp   = (div_q > 64'sd2147483647) ? 32'sh7fffffff :
                       (div_q < -64'sd2147483648) ? 32'sh80000000 : div_q[31:0];
  assign slew_lim_ppb = slew_lim_q * MS_PER_S;
  assign s_sum       = sample_q + div_q;
  assign s_new       = ($signed(s_sum) > $signed({37'd0, slew_lim_ppb}) ||
                        $signed(s_sum) < -$signed({37'd0, slew_lim_ppb})) ?
                       64'(drift_q) : s_sum;
  assign tot_sum     = {drift_total_q[31], drift_total_q} + {interval_q[31], interval_q};
  always_comb begin
    if (tot_sum > 33'sh07fffffff) tot_new = 32'sh7fffffff;
    else if (tot_sum < -33'sh080000000) tot_new = 32'sh80000000;
    else tot_new = tot_sum[31:0];
    if (tot_new > $signed({1'b0, drift_win_q})) tot_new = $signed({1'b0, drift_win_q});
  end
  assign prod_fix    = acc_q - (interval_q[31] ? mul_a_q : 64'sd0);
  assign drf_next    = 64'(drift_q) + div_q;
  assign period      = (adj_per_q == 16'd0) ? 17'd1 : {1'b0, adj_per_q};
  assign drift_prod  = drift_q * $signed(period);
  assign off_max     = (last_off_q > delta_q) ? last_off_q : delta_q;
  assign adj_sum     = div_q + off_max;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      sync_local_q    <= '0;
      sync_remote_q   <= '0;
      req_time_q      <= '0;
      path_avg_q      <= '0;
      path_cnt_q      <= '0;
      last_off_q      <= '0;
      last_off_time_q <= '0;
      last_adj_q      <= '0;
      drift_total_q   <= '0;
      drift_q         <= '0;
      out_valid_q     <= 1'b0;
      div_req_q.start <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q   <= ST_FIN;
            res_act_q <= ACT_NONE;
            res_val_q <= '0;
            unique case (operation_i)
              OP_SYNC: sync_local_q <= {1'b0, local_time_ns_i};
              OP_FOLLOWUP: begin
                sync_remote_q <= remote_time_ns_i;
                delta_q       <= fu_delta;
                now_q         <= {1'b0, local_time_ns_i};
                state_q       <= ST_CHK;
              end
              OP_SEND: begin
                if (req_time_q != 64'sd0) begin
                  res_act_q <= ACT_PENDING;
                end else begin
                  req_time_q <= {1'b0, local_time_ns_i};
                  res_val_q  <= {1'b0, local_time_ns_i};
                  res_act_q  <= ACT_SEND;
                end
              end
              default: begin
                req_time_q <= '0;
                res_val_q  <= path_avg_q;
                if (!ps_half[63] && ps_half < $signed({34'd0, path_lim_ns})) begin
                  res_act_q  <= ACT_PATH_OK;
                  path_cnt_q <= cnt_next;
                  if (cnt_next != 8'd0) begin
                    div_req_q.start <= 1'b1;
                    div_req_q.num   <= ps_half - path_avg_q;
                    div_req_q.den   <= {56'd0, cnt_next};
                    state_q         <= ST_PTH;
                  end
                end else begin
                  res_act_q <= ACT_PATH_BAD;
                end
              end
            endcase
          end
        end
        ST_PTH: begin
          if (div_done) begin
            path_avg_q <= path_avg_q + div_q;
            res_val_q  <= path_avg_q + div_q;
            state_q    <= ST_FIN;
          end
        end
        ST_CHK: begin
          // magnitude compared unsigned so the most negative offset still steps
          if ($unsigned(delta_mag) > {28'd0, thr_ns}) begin
            last_off_time_q <= step_time;
            last_off_q      <= '0;
            last_adj_q      <= '0;
            drift_total_q   <= '0;
            drift_q         <= '0;
            res_act_q       <= ACT_STEP;
            res_val_q       <= step_time;
            state_q         <= ST_FIN;
          end else if (!slew_en_q) begin
            res_act_q <= ACT_NONE;
            res_val_q <= '0;
            state_q   <= ST_FIN;
          end else begin
            div_req_q.start <= 1'b1;
            div_req_q.num   <= sync_local_q - last_off_time_q;
            div_req_q.den   <= {44'd0, NS_PER_MS};
            state_q         <= ST_INT;
          end
        end
        ST_INT: begin
          if (div_done) begin
            interval_q      <= int_clamp;
            div_req_q.start <= 1'b1;
            if (int_clamp > 32'sd0 && $unsigned(int_clamp) < {1'b0, sync_tmo_q}) begin
              div_req_q.num <= times1000(delta_q - last_off_q);
              div_req_q.den <= 64'(int_clamp);
              state_q       <= ST_SMP;
            end else begin
              sample_q      <= '0;
              div_req_q.num <= times1000(last_adj_q);
              div_req_q.den <= {47'd0, period};
              state_q       <= ST_ADJ;
            end
          end
        end
        ST_SMP: begin
          if (div_done) begin
            sample_q        <= div_q;
            div_req_q.start <= 1'b1;
            div_req_q.num   <= times1000(last_adj_q);
            div_req_q.den   <= {47'd0, period};
            state_q         <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          if (div_done) begin
            sample_q      <= s_new;
            drift_total_q <= tot_new;
            mul_a_q       <= s_new - 64'(drift_q);
            mul_b_q       <= interval_q;
            acc_q         <= '0;
            mul_cnt_q     <= '0;
            state_q       <= (tot_new != 32'sd0) ? ST_MUL : ST_PRD;
          end
        end
        ST_MUL: begin
          // shift-add over the 32 interval bits, low 64 bits kept
          if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
          mul_a_q   <= mul_a_q <<< 1;
          mul_b_q   <= mul_b_q >> 1;
          mul_cnt_q <= mul_cnt_q + 5'd1;
          if (mul_cnt_q == 5'd31) state_q <= ST_MFX;
        end
        ST_MFX: begin
          // mul_a now holds a<<32, the correction for a negative interval
          div_req_q.start <= 1'b1;
          div_req_q.num   <= prod_fix;
          div_req_q.den   <= 64'(drift_total_q);
          state_q         <= ST_DRF;
        end
        ST_DRF: begin
          if (div_done) begin
            if (drf_next > 64'sd134217727) drift_q <= 28'sh7ffffff;
            else if (drf_next < -64'sd134217728) drift_q <= 28'sh8000000;
            else drift_q <= drf_next[27:0];
            state_q <= ST_PRD;
          end
        end
        ST_PRD: begin
          div_req_q.start <= 1'b1;
          div_req_q.num   <= 64'(drift_prod);
          div_req_q.den   <= {54'd0, MS_PER_S};
          state_q         <= ST_END;
        end
        ST_END: begin
          if (div_done) begin
            last_off_q      <= delta_q;
            last_off_time_q <= sync_local_q;
            last_adj_q      <= adj_sum;
            res_act_q       <= ACT_SLEW;
            res_val_q       <= adj_sum;
            state_q         <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_act_q   <= res_act_q;
            out_val_q   <= res_val_q;
            out_drift_q <= drift_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o           = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign action_o             = out_act_q;
  assign value_ns_o           = out_val_q;
  assign drift_estimate_ppb_o = out_drift_q;

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q != ST_IDLE && state_q != ST_FIN))
    else $error("divider finished outside a request");
  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_valid_q || !out_stall_i)) |=>
      (out_valid_q && state_q == ST_IDLE))
    else $error("result not loaded into output register");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q != ST_IDLE))
    else $error("accepted request left the sequencer idle");

endmodule

### hw/rtl/css_div.sv
// iterative signed 64-bit divider, one quotient bit per cycle, truncating
module css_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  css_pkg::div_req_t  req_i,
  output logic               done_o,
  output logic signed [63:0] quotient_o
);
  import css_pkg::*;

  logic [63:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, neg_q, zero_q;
  logic [64:0] shifted, trial;

  assign shifted = {rem_q, quo_q[63]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= req_i.num[63] ? 64'd0 - req_i.num : req_i.num;
      den_q  <= req_i.den[63] ? 64'd0 - req_i.den : req_i.den;
      neg_q  <= req_i.num[63] ^ req_i.den[63];
      zero_q <= (req_i.den == 64'sd0);
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = zero_q ? 64'sd0 : (neg_q ? $signed(64'd0 - quo_q) : $signed(quo_q));

endmodule
